>>> src/oile_pkg.sv
// Shared constants, codes and types for the ordered index list engine.
package oile_pkg;

  // List capacity and entry width
  localparam int DEPTH      = 256;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);

  // Field widths fixed by the port definition
  localparam int OP_BITS  = 3;
  localparam int POS_BITS = 9;
  localparam int ST_BITS  = 2;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_MOVE      = 3'd2;
  localparam logic [OP_BITS-1:0] OP_SWAP      = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ      = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SEARCH_BK = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SEARCH_NA = 3'd6;

  // Status codes
  localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_BITS-1:0] ST_RANGE = 2'd2;

  // Cell commands
  localparam int CMD_BITS = 3;
  localparam logic [CMD_BITS-1:0] CMD_NONE     = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_SHIFT_UP = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_SHIFT_DN = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_SWAP     = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_COMPARE  = 3'd4;

  // Read tree geometry: one OR stage per group, then one over the groups
  localparam int TREE_FAN    = 16;
  localparam int TREE_GROUPS = (DEPTH + TREE_FAN - 1) / TREE_FAN;

  // Command broadcast to every cell
  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [IDX_BITS-1:0]   lo_b;
    logic [IDX_BITS-1:0]   hi_b;
    logic [VALUE_BITS-1:0] value_a;
    logic [VALUE_BITS-1:0] value_b;
    logic                  not_above;
  } cell_ctrl_t;

endpackage

>>> src/oile_cell.sv
// One list cell: holds an entry, shifts with its neighbours, compares against a key.
module oile_cell (
  input  logic                           clk,
  input  logic [oile_pkg::IDX_BITS-1:0]  index,
  input  oile_pkg::cell_ctrl_t           ctrl,
  input  logic [oile_pkg::IDX_BITS-1:0]  rd_addr,
  input  logic [oile_pkg::VALUE_BITS-1:0] left_value,
  input  logic [oile_pkg::VALUE_BITS-1:0] right_value,
  output logic [oile_pkg::VALUE_BITS-1:0] value,
  output logic [oile_pkg::VALUE_BITS-1:0] read_word,
  output logic                           pass_bit
);

  logic hit_lo;
  logic hit_hi;
  logic above_lo;
  logic below_hi;

  assign hit_lo   = (index == ctrl.lo_b);
  assign hit_hi   = (index == ctrl.hi_b);
  assign above_lo = (index > ctrl.lo_b);
  assign below_hi = (index < ctrl.hi_b);

  // Entry update
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      oile_pkg::CMD_SHIFT_UP: begin
        if (hit_lo) begin
          value <= ctrl.value_a;
        end else if (above_lo && (below_hi || hit_hi)) begin
          value <= left_value;
        end
      end
      oile_pkg::CMD_SHIFT_DN: begin
        if (hit_hi) begin
          value <= ctrl.value_a;
        end else if ((above_lo || hit_lo) && below_hi) begin
          value <= right_value;
        end
      end
      oile_pkg::CMD_SWAP: begin
        if (hit_lo) begin
          value <= ctrl.value_a;
        end else if (hit_hi) begin
          value <= ctrl.value_b;
        end
      end
      default: begin
      end
    endcase
  end

  // Search predicate, key carried in value_a
  always_ff @(posedge clk) begin
    if (ctrl.cmd == oile_pkg::CMD_COMPARE) begin
      pass_bit <= ctrl.not_above ? (value <= ctrl.value_a) : (value < ctrl.value_a);
    end
  end

  // Masked entry onto the read tree
  assign read_word = (index == rd_addr) ? value : '0;

endmodule

>>> src/oile_read_tree.sv
// Two-stage registered OR tree that gathers the one addressed cell word.
module oile_read_tree (
  input  logic                            clk,
  input  logic [oile_pkg::VALUE_BITS-1:0] words [oile_pkg::DEPTH],
  output logic [oile_pkg::VALUE_BITS-1:0] data
);

  logic [oile_pkg::VALUE_BITS-1:0] grp      [oile_pkg::TREE_GROUPS];
  logic [oile_pkg::VALUE_BITS-1:0] grp_next [oile_pkg::TREE_GROUPS];
  logic [oile_pkg::VALUE_BITS-1:0] data_next;

  // First stage: OR within each group
  always_comb begin
    for (int g = 0; g < oile_pkg::TREE_GROUPS; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < oile_pkg::TREE_FAN; k++) begin
        if (g * oile_pkg::TREE_FAN + k < oile_pkg::DEPTH) begin
          grp_next[g] = grp_next[g] | words[g * oile_pkg::TREE_FAN + k];
        end
      end
    end
  end

  // Second stage: OR over the groups
  always_comb begin
    data_next = '0;
    for (int g = 0; g < oile_pkg::TREE_GROUPS; g++) begin
      data_next = data_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    grp  <= grp_next;
    data <= data_next;
  end

endmodule

>>> src/ordered_index_list_engine.sv
// Top level: command sequencer over a chain of list cells and a read tree.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start, busy          | op, position, position_b, value_in
//  result   | done (one-cycle beat)| status, result_position, result_value,
//           |                      | entry_count
//
// A command beat is taken when start is high and busy is low; busy stays high until
// the cycle in which done marks the result beat. Insert, delete and any rejected
// command give their result straight from decode; read and move fetch one entry and
// swap fetches two, each fetch passing the two read tree stages plus the capture.
// Search takes one bisection step per cycle, then fetches the found entry when
// there is one.
// Reset clears the count and the sequencer; entry contents are not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module ordered_index_list_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [oile_pkg::OP_BITS-1:0]    op,
  input  logic [oile_pkg::POS_BITS-1:0]   position,
  input  logic [oile_pkg::POS_BITS-1:0]   position_b,
  input  logic [oile_pkg::VALUE_BITS-1:0] value_in,
  output logic                            busy,
  output logic                            done,
  output logic [oile_pkg::ST_BITS-1:0]    status,
  output logic [oile_pkg::POS_BITS-1:0]   result_position,
  output logic [oile_pkg::VALUE_BITS-1:0] result_value,
  output logic [oile_pkg::POS_BITS-1:0]   entry_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ_A = 3'd2;
  localparam logic [2:0] S_READ_B = 3'd3;
  localparam logic [2:0] S_APPLY  = 3'd4;
  localparam logic [2:0] S_SEARCH = 3'd5;

  localparam logic [1:0] TREE_WAIT = 2'd2;
  localparam logic [oile_pkg::IDX_BITS-1:0] LAST_IDX = oile_pkg::IDX_BITS'(oile_pkg::DEPTH - 1);

  logic [2:0]                      state;
  logic [oile_pkg::OP_BITS-1:0]    cur_op;
  logic [oile_pkg::POS_BITS-1:0]   pos_a;
  logic [oile_pkg::POS_BITS-1:0]   pos_b;
  logic [oile_pkg::VALUE_BITS-1:0] key;
  logic [oile_pkg::POS_BITS-1:0]   count;
  logic [oile_pkg::POS_BITS-1:0]   lo;
  logic [oile_pkg::POS_BITS-1:0]   hi;
  logic [oile_pkg::IDX_BITS-1:0]   rd_addr;
  logic [1:0]                      wait_cnt;
  logic [oile_pkg::VALUE_BITS-1:0] t_a;
  logic [oile_pkg::VALUE_BITS-1:0] t_b;

  logic [oile_pkg::VALUE_BITS-1:0] cell_value [oile_pkg::DEPTH];
  logic [oile_pkg::VALUE_BITS-1:0] read_words [oile_pkg::DEPTH];
  logic [oile_pkg::DEPTH-1:0]      pass_vec;
  logic [oile_pkg::VALUE_BITS-1:0] tree_out;
  oile_pkg::cell_ctrl_t            ctrl;

  logic                            err;
  logic [oile_pkg::ST_BITS-1:0]    err_code;
  logic [oile_pkg::POS_BITS-1:0]   count_after;
  logic                            move_down;
  logic                            move_up;
  logic [oile_pkg::POS_BITS-1:0]   pb_dec;
  logic [oile_pkg::POS_BITS-1:0]   landing;
  logic [oile_pkg::POS_BITS:0]     mid_sum;
  logic [oile_pkg::POS_BITS-1:0]   mid;
  logic                            mid_pass;

  assign busy = (state != S_IDLE);

  // Range and capacity checks on the latched command
  assign move_down = (({1'b0, pos_a} + (oile_pkg::POS_BITS + 1)'(1)) < {1'b0, pos_b});
  assign move_up   = (pos_b < pos_a);
  assign pb_dec    = pos_b - oile_pkg::POS_BITS'(1);
  assign landing   = move_down ? pb_dec : (move_up ? pos_b : pos_a);

  always_comb begin
    err      = 1'b0;
    err_code = oile_pkg::ST_RANGE;
    case (cur_op)
      oile_pkg::OP_INSERT: begin
        if (pos_a > count) begin
          err = 1'b1;
        end else if (count >= oile_pkg::POS_BITS'(oile_pkg::DEPTH)) begin
          err      = 1'b1;
          err_code = oile_pkg::ST_FULL;
        end
      end
      oile_pkg::OP_DELETE, oile_pkg::OP_READ: err = (pos_a >= count);
      oile_pkg::OP_SWAP:     err = (pos_a >= count) || (pos_b >= count);
      oile_pkg::OP_MOVE:     err = (pos_a >= count) || (pos_b > count);
      oile_pkg::OP_SEARCH_BK, oile_pkg::OP_SEARCH_NA: err = 1'b0;
      default:               err = 1'b1;
    endcase
  end

  // Entry count once the decoded command has taken effect
  always_comb begin
    count_after = count;
    if (!err) begin
      if (cur_op == oile_pkg::OP_INSERT) begin
        count_after = count + oile_pkg::POS_BITS'(1);
      end else if (cur_op == oile_pkg::OP_DELETE) begin
        count_after = count - oile_pkg::POS_BITS'(1);
      end
    end
  end

  // Bisection midpoint; mid stays below hi while lo < hi, so it then names a cell
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[oile_pkg::POS_BITS:1];
  assign mid_pass = pass_vec[mid[oile_pkg::IDX_BITS-1:0]];

  // Command broadcast to the cell chain
  always_comb begin
    ctrl.cmd       = oile_pkg::CMD_NONE;
    ctrl.lo_b      = pos_a[oile_pkg::IDX_BITS-1:0];
    ctrl.hi_b      = LAST_IDX;
    ctrl.value_a   = key;
    ctrl.value_b   = t_a;
    ctrl.not_above = (cur_op == oile_pkg::OP_SEARCH_NA);
    case (state)
      S_DECODE: begin
        if (!err) begin
          case (cur_op)
            oile_pkg::OP_INSERT:    ctrl.cmd = oile_pkg::CMD_SHIFT_UP;
            oile_pkg::OP_DELETE:    ctrl.cmd = oile_pkg::CMD_SHIFT_DN;
            oile_pkg::OP_SEARCH_BK,
            oile_pkg::OP_SEARCH_NA: ctrl.cmd = oile_pkg::CMD_COMPARE;
            default:                ctrl.cmd = oile_pkg::CMD_NONE;
          endcase
        end
      end
      S_APPLY: begin
        if (cur_op == oile_pkg::OP_SWAP) begin
          ctrl.cmd     = oile_pkg::CMD_SWAP;
          ctrl.hi_b    = pos_b[oile_pkg::IDX_BITS-1:0];
          ctrl.value_a = t_b;
          ctrl.value_b = t_a;
        end else if (move_down) begin
          ctrl.cmd     = oile_pkg::CMD_SHIFT_DN;
          ctrl.hi_b    = pb_dec[oile_pkg::IDX_BITS-1:0];
          ctrl.value_a = t_a;
        end else begin
          ctrl.cmd     = oile_pkg::CMD_SHIFT_UP;
          ctrl.lo_b    = pos_b[oile_pkg::IDX_BITS-1:0];
          ctrl.hi_b    = pos_a[oile_pkg::IDX_BITS-1:0];
          ctrl.value_a = t_a;
        end
      end
      default: ctrl.cmd = oile_pkg::CMD_NONE;
    endcase
  end

  // Cell chain
  for (genvar i = 0; i < oile_pkg::DEPTH; i++) begin : g_cell
    logic [oile_pkg::VALUE_BITS-1:0] left_v;
    logic [oile_pkg::VALUE_BITS-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_inner_l
      assign left_v = cell_value[i-1];
    end
    if (i == oile_pkg::DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner_r
      assign right_v = cell_value[i+1];
    end
    oile_cell u_cell (
      .clk         (clk),
      .index       (oile_pkg::IDX_BITS'(i)),
      .ctrl        (ctrl),
      .rd_addr     (rd_addr),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .read_word   (read_words[i]),
      .pass_bit    (pass_vec[i])
    );
  end

  oile_read_tree u_tree (
    .clk   (clk),
    .words (read_words),
    .data  (tree_out)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cur_op <= op;
            pos_a  <= position;
            pos_b  <= position_b;
            key    <= value_in;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          status          <= err ? err_code : oile_pkg::ST_OK;
          result_position <= pos_a;
          result_value    <= '0;
          entry_count     <= count_after;
          if (err) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            case (cur_op)
              oile_pkg::OP_INSERT, oile_pkg::OP_DELETE: begin
                count <= count_after;
                done  <= 1'b1;
                state <= S_IDLE;
              end
              oile_pkg::OP_MOVE: begin
                if (move_down || move_up) begin
                  rd_addr  <= pos_a[oile_pkg::IDX_BITS-1:0];
                  wait_cnt <= TREE_WAIT;
                  done     <= 1'b0;
                  state    <= S_READ_A;
                end else begin
                  done  <= 1'b1;
                  state <= S_IDLE;
                end
              end
              oile_pkg::OP_SWAP, oile_pkg::OP_READ: begin
                rd_addr  <= pos_a[oile_pkg::IDX_BITS-1:0];
                wait_cnt <= TREE_WAIT;
                done     <= 1'b0;
                state    <= S_READ_A;
              end
              oile_pkg::OP_SEARCH_BK, oile_pkg::OP_SEARCH_NA: begin
                lo    <= '0;
                hi    <= count;
                done  <= 1'b0;
                state <= S_SEARCH;
              end
              default: begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ_A: begin
          if (wait_cnt != 2'd0) begin
            wait_cnt <= wait_cnt - 2'd1;
            done     <= 1'b0;
          end else begin
            t_a <= tree_out;
            case (cur_op)
              oile_pkg::OP_SWAP: begin
                rd_addr  <= pos_b[oile_pkg::IDX_BITS-1:0];
                wait_cnt <= TREE_WAIT;
                done     <= 1'b0;
                state    <= S_READ_B;
              end
              oile_pkg::OP_MOVE: begin
                done  <= 1'b0;
                state <= S_APPLY;
              end
              oile_pkg::OP_SEARCH_BK, oile_pkg::OP_SEARCH_NA: begin
                status          <= oile_pkg::ST_OK;
                result_position <= hi;
                result_value    <= tree_out;
                entry_count     <= count;
                done            <= 1'b1;
                state           <= S_IDLE;
              end
              default: begin
                status          <= oile_pkg::ST_OK;
                result_position <= pos_a;
                result_value    <= tree_out;
                entry_count     <= count;
                done            <= 1'b1;
                state           <= S_IDLE;
              end
            endcase
          end
        end
        S_READ_B: begin
          done <= 1'b0;
          if (wait_cnt != 2'd0) begin
            wait_cnt <= wait_cnt - 2'd1;
          end else begin
            t_b   <= tree_out;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          status          <= oile_pkg::ST_OK;
          result_position <= (cur_op == oile_pkg::OP_MOVE) ? landing : pos_a;
          result_value    <= '0;
          entry_count     <= count;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_SEARCH: begin
          if (lo < hi) begin
            done <= 1'b0;
            if (mid_pass) begin
              lo <= mid + oile_pkg::POS_BITS'(1);
            end else begin
              hi <= mid;
            end
          end else if (hi < count) begin
            rd_addr  <= hi[oile_pkg::IDX_BITS-1:0];
            wait_cnt <= TREE_WAIT;
            done     <= 1'b0;
            state    <= S_READ_A;
          end else begin
            status          <= oile_pkg::ST_OK;
            result_position <= hi;
            result_value    <= '0;
            entry_count     <= count;
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE))
    else $error("result beat without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= oile_pkg::POS_BITS'(oile_pkg::DEPTH))
    else $error("entry count beyond capacity");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ((lo <= hi) && (hi <= count)))
    else $error("bisection bounds out of order");

  a_count_with_beat: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> done)
    else $error("entry count changed without a result beat");

endmodule
